// ===== rtl/s512_pkg.sv =====
// ----------------------------------------------------------------------------
// s512_pkg
// Shared types, constants and SHA-512 helper functions for the compression
// engine.
// ----------------------------------------------------------------------------
package s512_pkg;

    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 80;
    localparam int HASH_WORDS  = 8;

    typedef logic [63:0] word_t;

    // Working variables a..h; a sits in the top bits.
    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        word_t e;
        word_t f;
        word_t g;
        word_t h;
    } s512_vars_t;

    function automatic word_t rotr64(input word_t x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return rotr64(x, 28) ^ rotr64(x, 34) ^ rotr64(x, 39);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return rotr64(x, 14) ^ rotr64(x, 18) ^ rotr64(x, 41);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return rotr64(x, 1) ^ rotr64(x, 8) ^ (x >> 7);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return rotr64(x, 19) ^ rotr64(x, 61) ^ (x >> 6);
    endfunction

    function automatic word_t init_hash(input logic [2:0] idx);
        word_t r;
        unique case (idx)
            3'd0: r = 64'h6a09e667f3bcc908;
            3'd1: r = 64'hbb67ae8584caa73b;
            3'd2: r = 64'h3c6ef372fe94f82b;
            3'd3: r = 64'ha54ff53a5f1d36f1;
            3'd4: r = 64'h510e527fade682d1;
            3'd5: r = 64'h9b05688c2b3e6c1f;
            3'd6: r = 64'h1f83d9abfb41bd6b;
            3'd7: r = 64'h5be0cd19137e2179;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic word_t round_const(input logic [6:0] t);
        word_t r;
        unique case (t)
            7'd0:  r = 64'h428a2f98d728ae22;
            7'd1:  r = 64'h7137449123ef65cd;
            7'd2:  r = 64'hb5c0fbcfec4d3b2f;
            7'd3:  r = 64'he9b5dba58189dbbc;
            7'd4:  r = 64'h3956c25bf348b538;
            7'd5:  r = 64'h59f111f1b605d019;
            7'd6:  r = 64'h923f82a4af194f9b;
            7'd7:  r = 64'hab1c5ed5da6d8118;
            7'd8:  r = 64'hd807aa98a3030242;
            7'd9:  r = 64'h12835b0145706fbe;
            7'd10: r = 64'h243185be4ee4b28c;
            7'd11: r = 64'h550c7dc3d5ffb4e2;
            7'd12: r = 64'h72be5d74f27b896f;
            7'd13: r = 64'h80deb1fe3b1696b1;
            7'd14: r = 64'h9bdc06a725c71235;
            7'd15: r = 64'hc19bf174cf692694;
            7'd16: r = 64'he49b69c19ef14ad2;
            7'd17: r = 64'hefbe4786384f25e3;
            7'd18: r = 64'h0fc19dc68b8cd5b5;
            7'd19: r = 64'h240ca1cc77ac9c65;
            7'd20: r = 64'h2de92c6f592b0275;
            7'd21: r = 64'h4a7484aa6ea6e483;
            7'd22: r = 64'h5cb0a9dcbd41fbd4;
            7'd23: r = 64'h76f988da831153b5;
            7'd24: r = 64'h983e5152ee66dfab;
            7'd25: r = 64'ha831c66d2db43210;
            7'd26: r = 64'hb00327c898fb213f;
            7'd27: r = 64'hbf597fc7beef0ee4;
            7'd28: r = 64'hc6e00bf33da88fc2;
            7'd29: r = 64'hd5a79147930aa725;
            7'd30: r = 64'h06ca6351e003826f;
            7'd31: r = 64'h142929670a0e6e70;
            7'd32: r = 64'h27b70a8546d22ffc;
            7'd33: r = 64'h2e1b21385c26c926;
            7'd34: r = 64'h4d2c6dfc5ac42aed;
            7'd35: r = 64'h53380d139d95b3df;
            7'd36: r = 64'h650a73548baf63de;
            7'd37: r = 64'h766a0abb3c77b2a8;
            7'd38: r = 64'h81c2c92e47edaee6;
            7'd39: r = 64'h92722c851482353b;
            7'd40: r = 64'ha2bfe8a14cf10364;
            7'd41: r = 64'ha81a664bbc423001;
            7'd42: r = 64'hc24b8b70d0f89791;
            7'd43: r = 64'hc76c51a30654be30;
            7'd44: r = 64'hd192e819d6ef5218;
            7'd45: r = 64'hd69906245565a910;
            7'd46: r = 64'hf40e35855771202a;
            7'd47: r = 64'h106aa07032bbd1b8;
            7'd48: r = 64'h19a4c116b8d2d0c8;
            7'd49: r = 64'h1e376c085141ab53;
            7'd50: r = 64'h2748774cdf8eeb99;
            7'd51: r = 64'h34b0bcb5e19b48a8;
            7'd52: r = 64'h391c0cb3c5c95a63;
            7'd53: r = 64'h4ed8aa4ae3418acb;
            7'd54: r = 64'h5b9cca4f7763e373;
            7'd55: r = 64'h682e6ff3d6b2b8a3;
            7'd56: r = 64'h748f82ee5defb2fc;
            7'd57: r = 64'h78a5636f43172f60;
            7'd58: r = 64'h84c87814a1f0ab72;
            7'd59: r = 64'h8cc702081a6439ec;
            7'd60: r = 64'h90befffa23631e28;
            7'd61: r = 64'ha4506cebde82bde9;
            7'd62: r = 64'hbef9a3f7b2c67915;
            7'd63: r = 64'hc67178f2e372532b;
            7'd64: r = 64'hca273eceea26619c;
            7'd65: r = 64'hd186b8c721c0c207;
            7'd66: r = 64'heada7dd6cde0eb1e;
            7'd67: r = 64'hf57d4f7fee6ed178;
            7'd68: r = 64'h06f067aa72176fba;
            7'd69: r = 64'h0a637dc5a2c898a6;
            7'd70: r = 64'h113f9804bef90dae;
            7'd71: r = 64'h1b710b35131c471b;
            7'd72: r = 64'h28db77f523047d84;
            7'd73: r = 64'h32caab7b40c72493;
            7'd74: r = 64'h3c9ebe0a15c9bebc;
            7'd75: r = 64'h431d67c49c100d4c;
            7'd76: r = 64'h4cc5d4becb3e42b6;
            7'd77: r = 64'h597f299cfc657e2a;
            7'd78: r = 64'h5fcb6fab3ad6faec;
            7'd79: r = 64'h6c44198c4a475817;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/sha512_block_compression_top.sv =====
// ----------------------------------------------------------------------------
// sha512_block_compression_top
// SHA-512 compression engine: collects padded 1024-bit blocks as 16 words,
// compresses them into a chaining hash held in a small RAM, emits the digest.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata                 | tuser                        | tlast
//  --------+-----------+-----------------------+------------------------------+----------
//  s_      | in        | message_word [63:0]   | [0] new_message [1] final    | -
//  m_      | out       | digest_word  [63:0]   | [2:0] digest_index           | last_word
//
//  Per block: the 16 words are collected, a..h are loaded from the hash RAM,
//  80 rounds run at one round per cycle, and a..h are added back into the
//  hash RAM one word at a time over its single read port.
//  A final block then emits each digest word by read, capture and hand off.
//  s_tready is high only while a block is being collected; m_tdata holds while
//  m_tready is low. Reset returns to collecting with the hash at its initial value.
//  The hash RAM is not cleared: a flag makes it read as the initial value until
//  a write-back completes (a new_message block sets it again), so no clearing pass is needed.
// ----------------------------------------------------------------------------
module sha512_block_compression_top
    import s512_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] message_word
    input  logic [1:0]  s_tuser,   // [0] new_message, [1] final_block
    // digest words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] digest_index
    output logic        m_tlast    // last_word
);

    localparam logic [2:0] ST_COLLECT = 3'd0;
    localparam logic [2:0] ST_LOAD    = 3'd1;
    localparam logic [2:0] ST_ROUND   = 3'd2;
    localparam logic [2:0] ST_ADD     = 3'd3;
    localparam logic [2:0] ST_OUT_RD  = 3'd4;
    localparam logic [2:0] ST_OUT_CAP = 3'd5;
    localparam logic [2:0] ST_OUT_HLD = 3'd6;

    localparam logic [3:0] LAST_WORD_IDX = 4'(BLOCK_WORDS - 1);
    localparam logic [6:0] LAST_ROUND    = 7'(ROUNDS - 1);
    localparam logic [3:0] HASH_PASS_END = 4'(HASH_WORDS);
    localparam logic [2:0] LAST_DIGEST   = 3'(HASH_WORDS - 1);

    // control state
    logic [2:0] state_reg, state_next;
    logic [3:0] word_cnt_reg, word_cnt_next;
    logic [3:0] pass_cnt_reg, pass_cnt_next;      // load / write-back sweep, 0..8
    logic [6:0] round_cnt_reg, round_cnt_next;
    logic [2:0] out_idx_reg, out_idx_next;
    logic       hash_init_reg, hash_init_next;    // hash RAM reads as initial value
    logic       final_reg, final_next;
    logic       m_tvalid_reg, m_tvalid_next;

    // payload
    word_t      window_reg [BLOCK_WORDS];
    s512_vars_t vars_reg, vars_next;
    logic [2:0] rd_idx_reg;
    logic [63:0] m_tdata_reg;
    logic [2:0]  m_tuser_reg;
    logic        m_tlast_reg;

    // hash RAM port
    logic       ram_we;
    logic [2:0] ram_waddr;
    word_t      ram_wdata;
    logic [2:0] ram_raddr;
    word_t      ram_rdata;
    word_t      hash_rd;

    logic       s_accept;
    logic       window_shift;
    word_t      window_in;
    word_t      w_expand;
    s512_vars_t vars_round;
    logic [3:0] pass_m1;

    s512_ram #(
        .WIDTH (64),
        .DEPTH (HASH_WORDS)
    ) u_hash_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    s512_round u_round (
        .vars_in  (vars_reg),
        .w_in     (window_reg[0]),
        .k_in     (round_const(round_cnt_reg)),
        .vars_out (vars_round)
    );

    assign s_tready = (state_reg == ST_COLLECT);
    assign s_accept = s_tvalid && s_tready;
    assign pass_m1  = pass_cnt_reg - 4'd1;

    // substitute the initial value while the RAM has not been written back yet
    assign hash_rd = hash_init_reg ? init_hash(rd_idx_reg) : ram_rdata;

    // next schedule word from the 16-word window (oldest at index 0)
    assign w_expand = window_reg[0] + small_sigma0(window_reg[1])
                    + window_reg[9] + small_sigma1(window_reg[14]);

    assign window_shift = s_accept || (state_reg == ST_ROUND);
    assign window_in    = s_accept ? s_tdata : w_expand;

    always_comb begin
        state_next     = state_reg;
        word_cnt_next  = word_cnt_reg;
        pass_cnt_next  = pass_cnt_reg;
        round_cnt_next = round_cnt_reg;
        out_idx_next   = out_idx_reg;
        hash_init_next = hash_init_reg;
        final_next     = final_reg;
        m_tvalid_next  = m_tvalid_reg;
        vars_next      = vars_reg;
        ram_we         = 1'b0;
        ram_waddr      = pass_m1[2:0];
        ram_wdata      = hash_rd + vars_reg.a;
        ram_raddr      = pass_cnt_reg[2:0];

        unique case (state_reg)
            ST_COLLECT: begin
                if (s_accept) begin
                    word_cnt_next = word_cnt_reg + 4'd1;
                    if (word_cnt_reg == LAST_WORD_IDX) begin
                        // sample block flags on the last word
                        if (s_tuser[0]) begin
                            hash_init_next = 1'b1;
                        end
                        final_next    = s_tuser[1];
                        pass_cnt_next = '0;
                        state_next    = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                // issue reads 0..7, shift each returned word in behind a..h
                if (pass_cnt_reg != 4'd0) begin
                    vars_next = s512_vars_t'({vars_reg[447:0], hash_rd});
                end
                pass_cnt_next = pass_cnt_reg + 4'd1;
                if (pass_cnt_reg == HASH_PASS_END) begin
                    round_cnt_next = '0;
                    state_next     = ST_ROUND;
                end
            end
            ST_ROUND: begin
                vars_next      = vars_round;
                round_cnt_next = round_cnt_reg + 7'd1;
                if (round_cnt_reg == LAST_ROUND) begin
                    pass_cnt_next = '0;
                    state_next    = ST_ADD;
                end
            end
            ST_ADD: begin
                // read hash[i], write hash[i] + var[i] the cycle after; rotate a..h
                if (pass_cnt_reg != 4'd0) begin
                    ram_we    = 1'b1;
                    vars_next = s512_vars_t'({vars_reg[447:0], vars_reg.a});
                end
                pass_cnt_next = pass_cnt_reg + 4'd1;
                if (pass_cnt_reg == HASH_PASS_END) begin
                    hash_init_next = 1'b0;
                    out_idx_next   = '0;
                    state_next     = final_reg ? ST_OUT_RD : ST_COLLECT;
                end
            end
            ST_OUT_RD: begin
                ram_raddr  = out_idx_reg;
                state_next = ST_OUT_CAP;
            end
            ST_OUT_CAP: begin
                m_tvalid_next = 1'b1;
                state_next    = ST_OUT_HLD;
            end
            ST_OUT_HLD: begin
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    out_idx_next  = out_idx_reg + 3'd1;
                    state_next    = (out_idx_reg == LAST_DIGEST) ? ST_COLLECT : ST_OUT_RD;
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_COLLECT;
            word_cnt_reg  <= '0;
            pass_cnt_reg  <= '0;
            round_cnt_reg <= '0;
            out_idx_reg   <= '0;
            hash_init_reg <= 1'b1;
            final_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            word_cnt_reg  <= word_cnt_next;
            pass_cnt_reg  <= pass_cnt_next;
            round_cnt_reg <= round_cnt_next;
            out_idx_reg   <= out_idx_next;
            hash_init_reg <= hash_init_next;
            final_reg     <= final_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload: schedule window, working variables, read index, output word
    always_ff @(posedge aclk) begin
        vars_reg   <= vars_next;
        rd_idx_reg <= ram_raddr;
        if (window_shift) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                window_reg[i] <= window_reg[i + 1];
            end
            window_reg[BLOCK_WORDS - 1] <= window_in;
        end
        if (state_reg == ST_OUT_CAP) begin
            m_tdata_reg <= hash_rd;
            m_tuser_reg <= out_idx_reg;
            m_tlast_reg <= (out_idx_reg == LAST_DIGEST);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_round_to_add: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && round_cnt_reg == LAST_ROUND) |=> (state_reg == ST_ADD))
        else $error("round loop did not hand off to write-back");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while a digest word is pending");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == LAST_DIGEST)))
        else $error("tlast does not match digest index");

    a_init_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADD && pass_cnt_reg == HASH_PASS_END) |=> !hash_init_reg)
        else $error("initial-value flag kept after write-back");

endmodule

// ===== rtl/s512_ram.sv =====
// ----------------------------------------------------------------------------
// s512_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module s512_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/s512_round.sv =====
// ----------------------------------------------------------------------------
// s512_round
// One SHA-512 round: update working variables a..h from schedule word and
// round constant.
// ----------------------------------------------------------------------------
module s512_round
    import s512_pkg::*;
(
    input  s512_vars_t vars_in,
    input  word_t      w_in,
    input  word_t      k_in,
    output s512_vars_t vars_out
);

    word_t ch;
    word_t maj;
    word_t t1;
    word_t t2;

    assign ch  = (vars_in.e & vars_in.f) ^ (~vars_in.e & vars_in.g);
    assign maj = (vars_in.a & vars_in.b) ^ (vars_in.a & vars_in.c) ^ (vars_in.b & vars_in.c);
    assign t1  = vars_in.h + big_sigma1(vars_in.e) + ch + k_in + w_in;
    assign t2  = big_sigma0(vars_in.a) + maj;

    always_comb begin
        vars_out.h = vars_in.g;
        vars_out.g = vars_in.f;
        vars_out.f = vars_in.e;
        vars_out.e = vars_in.d + t1;
        vars_out.d = vars_in.c;
        vars_out.c = vars_in.b;
        vars_out.b = vars_in.a;
        vars_out.a = t1 + t2;
    end

endmodule
